// ===== design/blc_pkg.sv =====
// shared types, constants and the sequencer program of the life cell update block
package blc_pkg;

  localparam int PLANES = 24;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_RULE = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  localparam logic [17:0] RULE_RESET = 18'h01808;
  localparam logic [8:0]  SIZE_RESET = 9'd256;

  // neighbour select: low is up or left, high is down or right
  localparam logic [1:0] SEL_LO  = 2'd0;
  localparam logic [1:0] SEL_MID = 2'd1;
  localparam logic [1:0] SEL_HI  = 2'd2;

  // program steps
  localparam logic [3:0] STEP_IDLE = 4'd0;
  localparam logic [3:0] STEP_MODQ = 4'd1;
  localparam logic [3:0] STEP_MODR = 4'd2;
  localparam logic [3:0] STEP_CTR  = 4'd3;
  localparam logic [3:0] STEP_NB0  = 4'd4;
  localparam logic [3:0] STEP_NB1  = 4'd5;
  localparam logic [3:0] STEP_NB2  = 4'd6;
  localparam logic [3:0] STEP_NB3  = 4'd7;
  localparam logic [3:0] STEP_NB4  = 4'd8;
  localparam logic [3:0] STEP_NB5  = 4'd9;
  localparam logic [3:0] STEP_NB6  = 4'd10;
  localparam logic [3:0] STEP_NB7  = 4'd11;
  localparam logic [3:0] STEP_ACC  = 4'd12;
  localparam logic [3:0] STEP_FIN  = 4'd13;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_IF_WRITE,
    JC_WAIT_OUT,
    JC_ALWAYS
  } blc_jc_t;

  typedef struct packed {
    blc_jc_t    jcond;
    logic [3:0] target;
    logic [1:0] rsel;
    logic [1:0] csel;
    logic       mem_en;
    logic       wr_ok;
    logic       self_cap;
    logic       acc_en;
    logic       q_en;
    logic       m_en;
    logic       out_ld;
  } blc_uword_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] cell_row;
    logic [7:0] cell_col;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } blc_item_t;

  typedef struct packed {
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
  } blc_result_t;

  // control store: one word per step
  function automatic blc_uword_t blc_ucode(input logic [3:0] step);
    blc_uword_t w;
    w = '0;
    w.jcond  = JC_NEXT;
    w.target = STEP_IDLE;
    w.rsel   = SEL_MID;
    w.csel   = SEL_MID;
    case (step)
      STEP_IDLE: begin
        w.jcond = JC_WAIT_IN;
      end
      STEP_MODQ: begin
        w.q_en = 1'b1;
      end
      STEP_MODR: begin
        w.m_en = 1'b1;
      end
      STEP_CTR: begin
        w.mem_en = 1'b1;
        w.wr_ok  = 1'b1;
        w.jcond  = JC_IF_WRITE;
      end
      STEP_NB0: begin
        w.mem_en   = 1'b1;
        w.self_cap = 1'b1;
        w.rsel     = SEL_LO;
        w.csel     = SEL_LO;
      end
      STEP_NB1: begin
        w.mem_en = 1'b1;
        w.acc_en = 1'b1;
        w.rsel   = SEL_LO;
      end
      STEP_NB2: begin
        w.mem_en = 1'b1;
        w.acc_en = 1'b1;
        w.rsel   = SEL_LO;
        w.csel   = SEL_HI;
      end
      STEP_NB3: begin
        w.mem_en = 1'b1;
        w.acc_en = 1'b1;
        w.csel   = SEL_LO;
      end
      STEP_NB4: begin
        w.mem_en = 1'b1;
        w.acc_en = 1'b1;
        w.csel   = SEL_HI;
      end
      STEP_NB5: begin
        w.mem_en = 1'b1;
        w.acc_en = 1'b1;
        w.rsel   = SEL_HI;
        w.csel   = SEL_LO;
      end
      STEP_NB6: begin
        w.mem_en = 1'b1;
        w.acc_en = 1'b1;
        w.rsel   = SEL_HI;
      end
      STEP_NB7: begin
        w.mem_en = 1'b1;
        w.acc_en = 1'b1;
        w.rsel   = SEL_HI;
        w.csel   = SEL_HI;
      end
      STEP_ACC: begin
        w.acc_en = 1'b1;
      end
      STEP_FIN: begin
        w.out_ld = 1'b1;
        w.jcond  = JC_WAIT_OUT;
      end
      default: begin
        w.jcond = JC_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/blc_ram.sv =====
// single-port frame memory with registered read
module blc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bitplane_life_cell_update.sv =====
// top level: microcoded life cell update over a 24-plane rgb frame
//
//  port group  direction  payload       handshake
//  in_*        input      blc_item_t    in_valid / in_stall
//  out_*       output     blc_result_t  out_valid / out_stall
//  cfg_*       input      32-bit regs   apb-style, pready tied high
//
// a write item ends at its write step; an evaluate item ends after the rule lookup,
// plus any wait on out_stall, and its length is set by the single-port frame memory:
// the cell and its eight neighbours are read one word per cycle, then the rule lookup
// rst_n is synchronous; frame contents are not cleared and must be written before use
// a finished result waits in the output register while the next item is taken
module bitplane_life_cell_update #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  blc_pkg::blc_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output blc_pkg::blc_result_t out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  import blc_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 13;
  // reciprocal for mod by the grid limits, exact for 8-bit coordinates
  localparam int MOD_S = 21;
  localparam int MOD_W = 30;
  localparam int ROW_M = (1 << MOD_S) / MAX_ROWS + 1;
  localparam int COL_M = (1 << MOD_S) / MAX_COLS + 1;

  // configuration
  logic [17:0] rule_r, rule_nxt;
  logic [8:0]  rows_r, rows_nxt;
  logic [8:0]  cols_r, cols_nxt;
  logic        cfg_wr;

  // sequencer
  logic [3:0]  step_r, step_nxt;
  blc_uword_t  uw;
  logic        in_acc;
  logic        out_free;

  // datapath
  blc_item_t   item_r, item_nxt;
  logic [7:0]  q_row_r, q_row_nxt;
  logic [7:0]  q_col_r, q_col_nxt;
  logic [RW-1:0]  rm_row_r, rm_row_nxt;
  logic [CLW-1:0] rm_col_r, rm_col_nxt;
  logic [MOD_W-1:0] q_row_prod, q_col_prod;
  logic [20:0] r_row_full, r_col_full;
  logic [RW-1:0]  rows_m1, up_m, dn_m, ra;
  logic [CLW-1:0] cols_m1, lf_m, rt_m, ca;
  logic [PW-1:0]  addr_full;
  logic [AW-1:0]  ram_addr;
  logic           ram_we;
  logic [23:0]    ram_rdata;
  logic [23:0]    self_r, self_nxt;
  logic [3:0]     cnt_r [PLANES];
  logic [3:0]     cnt_nxt [PLANES];
  logic [23:0]    life;
  logic [4:0]     pos [PLANES];

  // output register
  logic        out_valid_r, out_valid_nxt;
  blc_result_t out_data_r, out_data_nxt;

  // ---------------- configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    rule_nxt = rule_r;
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_RULE: rule_nxt = cfg_pwdata[17:0];
        REG_ROWS: rows_nxt = cfg_pwdata[8:0];
        REG_COLS: cols_nxt = cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RULE: cfg_prdata = {14'd0, rule_r};
      REG_ROWS: cfg_prdata = {23'd0, rows_r};
      REG_COLS: cfg_prdata = {23'd0, cols_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- sequencer
  assign uw       = blc_ucode(step_r);
  assign in_stall = (step_r != STEP_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    case (uw.jcond)
      JC_NEXT:     step_nxt = step_r + 4'd1;
      JC_WAIT_IN:  step_nxt = in_valid ? step_r + 4'd1 : step_r;
      JC_IF_WRITE: step_nxt = (item_r.req_type == REQ_WRITE) ? uw.target : step_r + 4'd1;
      JC_WAIT_OUT: step_nxt = out_free ? uw.target : step_r;
      JC_ALWAYS:   step_nxt = uw.target;
      default:     step_nxt = STEP_IDLE;
    endcase
  end

  // ---------------- coordinate reduction into the store
  assign q_row_prod = MOD_W'(item_r.cell_row) * MOD_W'(ROW_M);
  assign q_col_prod = MOD_W'(item_r.cell_col) * MOD_W'(COL_M);
  assign r_row_full = 21'(item_r.cell_row) - 21'(q_row_r) * 21'(MAX_ROWS);
  assign r_col_full = 21'(item_r.cell_col) - 21'(q_col_r) * 21'(MAX_COLS);

  always_comb begin
    item_nxt   = in_acc ? in_data : item_r;
    q_row_nxt  = uw.q_en ? q_row_prod[MOD_S+7:MOD_S] : q_row_r;
    q_col_nxt  = uw.q_en ? q_col_prod[MOD_S+7:MOD_S] : q_col_r;
    rm_row_nxt = uw.m_en ? r_row_full[RW-1:0] : rm_row_r;
    rm_col_nxt = uw.m_en ? r_col_full[CLW-1:0] : rm_col_r;
  end

  // grid size in use, zero taken as one, clamped to the store
  always_comb begin
    if (rows_r == 9'd0) begin
      rows_m1 = '0;
    end else if (13'(rows_r) > 13'(MAX_ROWS)) begin
      rows_m1 = RW'(MAX_ROWS - 1);
    end else begin
      rows_m1 = RW'(rows_r - 9'd1);
    end
    if (cols_r == 9'd0) begin
      cols_m1 = '0;
    end else if (13'(cols_r) > 13'(MAX_COLS)) begin
      cols_m1 = CLW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CLW'(cols_r - 9'd1);
    end
  end

  // wrapped neighbours, already reduced into the store
  always_comb begin
    if (item_r.cell_row == 8'd0) begin
      up_m = rows_m1;
    end else if (rm_row_r == '0) begin
      up_m = RW'(MAX_ROWS - 1);
    end else begin
      up_m = rm_row_r - RW'(1);
    end
    if ((13'(item_r.cell_row) + 13'd1) > 13'(rows_m1)) begin
      dn_m = '0;
    end else if (rm_row_r == RW'(MAX_ROWS - 1)) begin
      dn_m = '0;
    end else begin
      dn_m = rm_row_r + RW'(1);
    end
    if (item_r.cell_col == 8'd0) begin
      lf_m = cols_m1;
    end else if (rm_col_r == '0) begin
      lf_m = CLW'(MAX_COLS - 1);
    end else begin
      lf_m = rm_col_r - CLW'(1);
    end
    if ((13'(item_r.cell_col) + 13'd1) > 13'(cols_m1)) begin
      rt_m = '0;
    end else if (rm_col_r == CLW'(MAX_COLS - 1)) begin
      rt_m = '0;
    end else begin
      rt_m = rm_col_r + CLW'(1);
    end
  end

  always_comb begin
    case (uw.rsel)
      SEL_LO:  ra = up_m;
      SEL_HI:  ra = dn_m;
      default: ra = rm_row_r;
    endcase
    case (uw.csel)
      SEL_LO:  ca = lf_m;
      SEL_HI:  ca = rt_m;
      default: ca = rm_col_r;
    endcase
  end

  assign addr_full = PW'(ra) * PW'(MAX_COLS) + PW'(ca);
  assign ram_addr  = addr_full[AW-1:0];
  assign ram_we    = uw.wr_ok & (item_r.req_type == REQ_WRITE);

  blc_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .en   (uw.mem_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata({item_r.red_in, item_r.green_in, item_r.blue_in}),
    .rdata(ram_rdata)
  );

  // ---------------- per-plane neighbour counts
  always_comb begin
    self_nxt = uw.self_cap ? ram_rdata : self_r;
    for (int b = 0; b < PLANES; b++) begin
      if (uw.self_cap) begin
        cnt_nxt[b] = 4'd0;
      end else if (uw.acc_en) begin
        cnt_nxt[b] = cnt_r[b] + {3'd0, ram_rdata[b]};
      end else begin
        cnt_nxt[b] = cnt_r[b];
      end
    end
  end

  // live cells look at the survival half of the rule
  always_comb begin
    for (int b = 0; b < PLANES; b++) begin
      pos[b]  = self_r[b] ? 5'd9 + {1'b0, cnt_r[b]} : {1'b0, cnt_r[b]};
      life[b] = rule_r[pos[b]];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (uw.out_ld & out_free) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.out_row    = item_r.cell_row;
      out_data_nxt.out_col    = item_r.cell_col;
      out_data_nxt.red_next   = life[23:16];
      out_data_nxt.green_next = life[15:8];
      out_data_nxt.blue_next  = life[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r      <= RULE_RESET;
      rows_r      <= SIZE_RESET;
      cols_r      <= SIZE_RESET;
      step_r      <= STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      rule_r      <= rule_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    q_row_r    <= q_row_nxt;
    q_col_r    <= q_col_nxt;
    rm_row_r   <= rm_row_nxt;
    rm_col_r   <= rm_col_nxt;
    self_r     <= self_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // a result only appears out of the final step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r) == STEP_FIN)
    else $error("result raised outside the final step");

  // frame writes only come from write items
  a_we_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (item_r.req_type == REQ_WRITE && step_r == STEP_CTR))
    else $error("frame written by an evaluate item");

  // the step counter stays inside the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_FIN)
    else $error("step counter beyond the program");

  // a full, stalled output holds the sequencer in the final step
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_FIN && out_valid_r && out_stall) |=> step_r == STEP_FIN)
    else $error("final step left while the output was blocked");

  // a write item finishes without a result and returns to idle
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_CTR && item_r.req_type == REQ_WRITE) |=> step_r == STEP_IDLE)
    else $error("write item did not return to idle");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the bitplane life cell update block
`timescale 1ns / 100ps

module testbench;
  import blc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 125;

  typedef logic [8:0][15:0] nbhd_t;

  typedef struct packed {
    logic        typed;
    blc_item_t   item;
    logic [23:0] want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  blc_item_t   in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  blc_result_t out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state: frame copy and register shadows
  logic [23:0] frame_mem [0:65535];
  bit          written_map [0:65535];
  logic [17:0] rule_reg;
  logic [8:0]  rows_reg;
  logic [8:0]  cols_reg;

  blc_result_t next_colours [$];
  blc_result_t head_res;
  dir_row_t    dir_tab [20];

  logic        steady = 1'b0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          fail_count = 0;
  int unsigned cycles = 0;

  bitplane_life_cell_update DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int grid_span(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // slot 0 is the cell itself, 1..8 its wrapped neighbours
  function automatic nbhd_t cell_hood(logic [7:0] r, logic [7:0] c);
    int nr, nc, up, dn, lf, rt;
    nbhd_t h;
    nr = grid_span(rows_reg);
    nc = grid_span(cols_reg);
    up = (r == 0) ? nr - 1 : r - 1;
    dn = (r + 1 > nr - 1) ? 0 : r + 1;
    lf = (c == 0) ? nc - 1 : c - 1;
    rt = (c + 1 > nc - 1) ? 0 : c + 1;
    h[0] = {r, c};
    h[1] = {8'(up), 8'(lf)};
    h[2] = {8'(up), c};
    h[3] = {8'(up), 8'(rt)};
    h[4] = {r, 8'(lf)};
    h[5] = {r, 8'(rt)};
    h[6] = {8'(dn), 8'(lf)};
    h[7] = {8'(dn), c};
    h[8] = {8'(dn), 8'(rt)};
    return h;
  endfunction

  function automatic blc_result_t life_next(logic [7:0] r, logic [7:0] c);
    nbhd_t       hood;
    logic [23:0] self_px;
    logic [23:0] nxt;
    int          cnt, pos;
    blc_result_t res;
    hood = cell_hood(r, c);
    self_px = frame_mem[hood[0]];
    for (int b = 0; b < PLANES; b++) begin
      cnt = 0;
      for (int k = 1; k < 9; k++) cnt += frame_mem[hood[k]][b];
      pos = self_px[b] ? 9 + cnt : cnt;
      nxt[b] = rule_reg[pos];
    end
    res.out_row    = r;
    res.out_col    = c;
    res.red_next   = nxt[23:16];
    res.green_next = nxt[15:8];
    res.blue_next  = nxt[7:0];
    return res;
  endfunction

  function automatic blc_item_t mk_item(logic req, logic [7:0] r, logic [7:0] c,
                                        logic [23:0] rgb);
    blc_item_t it;
    it.req_type = req;
    it.cell_row = r;
    it.cell_col = c;
    it.red_in   = rgb[23:16];
    it.green_in = rgb[15:8];
    it.blue_in  = rgb[7:0];
    return it;
  endfunction

  function automatic dir_row_t dir_row(logic req, logic [7:0] r, logic [7:0] c,
                                       logic [23:0] rgb, logic typed, logic [23:0] want);
    dir_row_t d;
    d.typed = typed;
    d.item  = mk_item(req, r, c, rgb);
    d.want  = want;
    return d;
  endfunction

  // bias towards empty and full pixels so neighbour counts reach their extremes
  function automatic logic [23:0] rand_rgb();
    case ($urandom_range(0, 3))
      0: begin
        return 24'h000000;
      end
      1: begin
        return 24'hFFFFFF;
      end
      default: begin
        return 24'($urandom);
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_coord(int n);
    case ($urandom_range(0, 9))
      0: begin
        return 8'($urandom_range(0, 255));
      end
      1: begin
        return 8'd0;
      end
      2: begin
        return 8'(n - 1);
      end
      3: begin
        return 8'd255;
      end
      default: begin
        if (n <= 16) return 8'($urandom_range(0, n - 1));
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(n - 4, n - 1));
      end
    endcase
  endfunction

  task automatic push_word(input blc_item_t it, input logic typed, input logic [23:0] want);
    blc_result_t res;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.req_type == REQ_WRITE) begin
      frame_mem[{it.cell_row, it.cell_col}] = {it.red_in, it.green_in, it.blue_in};
      written_map[{it.cell_row, it.cell_col}] = 1'b1;
    end else begin
      if (typed) begin
        res.out_row    = it.cell_row;
        res.out_col    = it.cell_col;
        res.red_next   = want[23:16];
        res.green_next = want[15:8];
        res.blue_next  = want[7:0];
      end else begin
        res = life_next(it.cell_row, it.cell_col);
      end
      next_colours.push_back(res);
    end
    if (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_RULE: begin
        rule_reg = val[17:0];
      end
      REG_ROWS: begin
        rows_reg = val[8:0];
      end
      REG_COLS: begin
        cols_reg = val[8:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // a write gives no result, so allow for one still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (next_colours.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [7:0]  r, c;
    logic [31:0] rv, nr, nc;
    nbhd_t       hood;
    int          sent;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    rule_reg    = RULE_RESET;
    rows_reg    = SIZE_RESET;
    cols_reg    = SIZE_RESET;

    // solid block around (1,1), then an empty strip across the wrap corner, then mixed writes and evaluates
    for (int i = 0; i < 9; i++)
      dir_tab[i] = dir_row(REQ_WRITE, 8'(i / 3), 8'(i % 3), 24'hFFFFFF, 1'b0, 24'h0);
    dir_tab[9]  = dir_row(REQ_EVAL,  8'd1,   8'd1,   24'h000000, 1'b1, 24'h000000);
    dir_tab[10] = dir_row(REQ_WRITE, 8'd255, 8'd255, 24'h000000, 1'b0, 24'h0);
    dir_tab[11] = dir_row(REQ_WRITE, 8'd255, 8'd0,   24'h000000, 1'b0, 24'h0);
    dir_tab[12] = dir_row(REQ_WRITE, 8'd255, 8'd1,   24'h000000, 1'b0, 24'h0);
    dir_tab[13] = dir_row(REQ_WRITE, 8'd0,   8'd255, 24'h000000, 1'b0, 24'h0);
    dir_tab[14] = dir_row(REQ_WRITE, 8'd1,   8'd255, 24'h000000, 1'b0, 24'h0);
    dir_tab[15] = dir_row(REQ_EVAL,  8'd0,   8'd0,   24'hFFFFFF, 1'b1, 24'hFFFFFF);
    dir_tab[16] = dir_row(REQ_WRITE, 8'd255, 8'd2,   24'h00FF00, 1'b0, 24'h0);
    dir_tab[17] = dir_row(REQ_WRITE, 8'd1,   8'd1,   24'hA53C0F, 1'b0, 24'h0);
    dir_tab[18] = dir_row(REQ_EVAL,  8'd0,   8'd1,   24'h5A5A5A, 1'b0, 24'h0);
    dir_tab[19] = dir_row(REQ_EVAL,  8'd1,   8'd1,   24'h000000, 1'b1, 24'h000000);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 20; i++) push_word(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          rv = $urandom; nr = 32'd4; nc = 32'd5;
        end
        1: begin
          rv = 32'hFFFFFFFF; nr = 32'd1; nc = 32'd1;
        end
        2: begin
          rv = 32'h00000000; nr = 32'd0; nc = 32'd0;
        end
        3: begin
          rv = $urandom; nr = 32'd256; nc = 32'd256;
        end
        4: begin
          rv = $urandom; nr = 32'd511; nc = 32'd300;
        end
        5: begin
          rv = $urandom; nr = 32'd3; nc = 32'd256;
        end
        6: begin
          rv = $urandom; nr = 32'd2; nc = 32'd7;
        end
        default: begin
          rv = 32'(RULE_RESET); nr = 32'd8; nc = 32'd8;
        end
      endcase
      cfg_write(REG_RULE, rv);
      cfg_write(REG_ROWS, nr);
      cfg_write(REG_COLS, nc);
      if (p == 4) steady <= 1'b1;
      // receiver holds off while words keep coming, so the block backs up
      if (p == 5) hold_asks <= hold_asks + 1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        r = pick_coord(grid_span(rows_reg));
        c = pick_coord(grid_span(cols_reg));
        if ($urandom_range(0, 3) == 0) begin
          push_word(mk_item(REQ_WRITE, r, c, rand_rgb()), 1'b0, 24'h0);
          sent++;
        end else begin
          // fill any neighbour not yet loaded, then evaluate
          hood = cell_hood(r, c);
          for (int k = 0; k < 9; k++) begin
            if (!written_map[hood[k]]) begin
              push_word(mk_item(REQ_WRITE, hood[k][15:8], hood[k][7:0], rand_rgb()),
                        1'b0, 24'h0);
              sent++;
            end
          end
          push_word(mk_item(REQ_EVAL, r, c, 24'($urandom)), 1'b0, 24'h0);
          sent++;
        end
      end
      steady <= 1'b0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, and the compare
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_seen <= hold_asks;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 26);
    end

    if (rst_n && out_valid && !out_stall) begin
      if (next_colours.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, out_data);
        fail_count++;
      end else begin
        head_res = next_colours.pop_front();
        if (head_res.out_row !== out_data.out_row) begin
          $display("%0t: out_row expected %h actual %h", $time,
                   head_res.out_row, out_data.out_row);
          fail_count++;
        end
        if (head_res.out_col !== out_data.out_col) begin
          $display("%0t: out_col expected %h actual %h", $time,
                   head_res.out_col, out_data.out_col);
          fail_count++;
        end
        if (head_res.red_next !== out_data.red_next) begin
          $display("%0t: red_next expected %h actual %h", $time,
                   head_res.red_next, out_data.red_next);
          fail_count++;
        end
        if (head_res.green_next !== out_data.green_next) begin
          $display("%0t: green_next expected %h actual %h", $time,
                   head_res.green_next, out_data.green_next);
          fail_count++;
        end
        if (head_res.blue_next !== out_data.blue_next) begin
          $display("%0t: blue_next expected %h actual %h", $time,
                   head_res.blue_next, out_data.blue_next);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// ===== bitplane_life_cell_update.f =====
design/blc_pkg.sv
design/blc_ram.sv
design/bitplane_life_cell_update.sv
tb/testbench.sv
